// ----- src/ptc_pkg.sv -----
// ptc_pkg: shared widths, register indexes, constants and the calibration word struct
// for the pressure/temperature compensation unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	// field widths
	localparam int unsigned CAL_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned RAW_W     = 24;
	localparam int unsigned PRESS_W   = 32;
	localparam int unsigned TEMP_W    = 19;

	// internal widths
	localparam int unsigned DT_W    = RAW_W + 1;      // raw temperature minus reference
	localparam int unsigned PROD_W  = DT_W + CAL_W + 1; // coefficient times dt
	localparam int unsigned DTEMP_W = 18;             // temp minus 2000
	localparam int unsigned SQ_W    = 35;             // squared temperature deviation
	localparam int unsigned CORR_W  = 38;             // second-order correction
	localparam int unsigned ACC_W   = 40;             // offset and sensitivity
	localparam int unsigned SPLIT_W = 20;             // low slice of sensitivity
	localparam int unsigned PD_W    = 43;             // d1*sens >>> 21

	// register indexes
	localparam logic [CFG_IDX_W-1:0] IDX_PRESSURE_SENSITIVITY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_PRESSURE_OFFSET       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_SENSITIVITY_TEMP_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_OFFSET_TEMP_COEF      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] IDX_TEMPERATURE_COEF      = 3'd5;

	// temperature thresholds, in 0.01 degC
	localparam logic signed [TEMP_W-1:0] TEMP_REF   = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_COLD  = -19'sd1500;
	// cold threshold relative to the reference point
	localparam logic signed [TEMP_W-1:0] COLD_DELTA = TEMP_COLD - TEMP_REF;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sensitivity_temp_coef;
		logic [CAL_W-1:0] offset_temp_coef;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temperature_coef;
	} calib_t;

endpackage

`default_nettype wire

// ----- src/ptc_regs.sv -----
// ptc_regs: calibration word register file written through the configuration channel
// depends on ptc_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptc_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [ptc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [ptc_pkg::CAL_W-1:0]        cfg_data,
	output ptc_pkg::calib_t                  calib
);
	import ptc_pkg::*;

	calib_t calib_q;

	assign cfg_ready = 1'b1;
	assign calib     = calib_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				IDX_PRESSURE_SENSITIVITY:  calib_q.pressure_sensitivity  <= cfg_data;
				IDX_PRESSURE_OFFSET:       calib_q.pressure_offset       <= cfg_data;
				IDX_SENSITIVITY_TEMP_COEF: calib_q.sensitivity_temp_coef <= cfg_data;
				IDX_OFFSET_TEMP_COEF:      calib_q.offset_temp_coef      <= cfg_data;
				IDX_REFERENCE_TEMPERATURE: calib_q.reference_temperature <= cfg_data;
				IDX_TEMPERATURE_COEF:      calib_q.temperature_coef      <= cfg_data;
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/pressure_temperature_compensation_unit.sv -----
// pressure_temperature_compensation_unit: nine-stage compensation pipeline, top level
// depends on ptc_pkg and ptc_regs
`timescale 1ns / 1ps
`default_nettype none

// Takes one pair of raw 24-bit readings (pressure, temperature) per transaction and
// returns compensated pressure (0.01 mbar, low 32 bits) and temperature (0.01 degC).
// Throughput is one transaction per cycle while out_stall is low; from input accept to
// output valid it passes the nine register stages of the datapath (dt, coefficient
// products, offset/sensitivity, squares, corrections, apply, split d1*sens product,
// recombine, final shift). Every stage holds its own valid bit and advances when it is
// empty or the stage after it moves, so bubbles collapse and the input side keeps
// accepting while a finished result waits on out_stall, as long as a stage is free.
// in_stall is only raised when all nine stages are full and the output is stalled.
// Calibration words reset to zero and must be written while no transaction is in flight.
module pressure_temperature_compensation_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration channel
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [ptc_pkg::CAL_W-1:0]          cfg_data,
	// input channel
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [ptc_pkg::RAW_W-1:0]          raw_pressure,
	input  wire  [ptc_pkg::RAW_W-1:0]          raw_temperature,
	// output channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [ptc_pkg::PRESS_W-1:0] pressure,
	output logic signed [ptc_pkg::TEMP_W-1:0]  temperature
);
	import ptc_pkg::*;

	calib_t calib;

	ptc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.calib     (calib)
	);

	// ---------------------------------------------------------------------------
	// stage valid bits and advance enables
	// ---------------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8, adv_s9;

	// a stage loads when it is empty or its contents move on
	assign adv_s9 = !valid_s9 || !out_stall;
	assign adv_s8 = !valid_s8 || adv_s9;
	assign adv_s7 = !valid_s7 || adv_s8;
	assign adv_s6 = !valid_s6 || adv_s7;
	assign adv_s5 = !valid_s5 || adv_s6;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
			if (adv_s7) valid_s7 <= valid_s6;
			if (adv_s8) valid_s8 <= valid_s7;
			if (adv_s9) valid_s9 <= valid_s8;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 1: dt = d2 - c5*256
	// ---------------------------------------------------------------------------
	logic signed [DT_W-1:0]  dt_s1;
	logic        [RAW_W-1:0] d1_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dt_s1 <= $signed({1'b0, raw_temperature})
				- $signed({1'b0, calib.reference_temperature, 8'b0});
			d1_s1 <= raw_pressure;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 2: the three coefficient products against dt
	// ---------------------------------------------------------------------------
	logic signed [PROD_W-1:0] off_prod_s2;
	logic signed [PROD_W-1:0] sens_prod_s2;
	logic signed [PROD_W-1:0] temp_prod_s2;
	logic        [RAW_W-1:0]  d1_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			off_prod_s2  <= $signed({1'b0, calib.offset_temp_coef}) * dt_s1;
			sens_prod_s2 <= $signed({1'b0, calib.sensitivity_temp_coef}) * dt_s1;
			temp_prod_s2 <= $signed({1'b0, calib.temperature_coef}) * dt_s1;
			d1_s2        <= d1_s1;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 3: first-order offset, sensitivity and temperature
	// ---------------------------------------------------------------------------
	logic signed [DTEMP_W-1:0] dtemp;      // temp - 2000 = dt*c6 >>> 23
	logic signed [ACC_W-1:0]   off0_s3;
	logic signed [ACC_W-1:0]   sens0_s3;
	logic signed [DTEMP_W-1:0] dtemp_s3;
	logic signed [TEMP_W-1:0]  cold_dev_s3; // temp + 1500
	logic signed [TEMP_W-1:0]  temp_s3;
	logic                      warm_low_s3; // below 20 degC
	logic                      cold_s3;     // below -15 degC
	logic        [RAW_W-1:0]   d1_s3;

	// product range stays inside 41 bits, so the slice is the floor shift
	assign dtemp = temp_prod_s2[PROD_W-2:23];

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			off0_s3     <= $signed({8'b0, calib.pressure_offset, 16'b0})
				+ $signed({{5{off_prod_s2[PROD_W-1]}}, off_prod_s2[PROD_W-1:7]});
			sens0_s3    <= $signed({9'b0, calib.pressure_sensitivity, 15'b0})
				+ $signed({{6{sens_prod_s2[PROD_W-1]}}, sens_prod_s2[PROD_W-1:8]});
			dtemp_s3    <= dtemp;
			cold_dev_s3 <= $signed({dtemp[DTEMP_W-1], dtemp}) - COLD_DELTA;
			temp_s3     <= $signed({dtemp[DTEMP_W-1], dtemp}) + TEMP_REF;
			warm_low_s3 <= dtemp[DTEMP_W-1];
			cold_s3     <= $signed({dtemp[DTEMP_W-1], dtemp}) < COLD_DELTA;
			d1_s3       <= d1_s2;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 4: squares of the temperature deviations
	// ---------------------------------------------------------------------------
	logic signed [2*DTEMP_W-1:0] sq_low_full;
	logic signed [2*TEMP_W-1:0]  sq_cold_full;
	logic        [SQ_W-1:0]      sq_low_s4;
	logic        [SQ_W-1:0]      sq_cold_s4;
	logic signed [ACC_W-1:0]     off0_s4;
	logic signed [ACC_W-1:0]     sens0_s4;
	logic signed [TEMP_W-1:0]    temp_s4;
	logic                        warm_low_s4;
	logic                        cold_s4;
	logic        [RAW_W-1:0]     d1_s4;

	assign sq_low_full  = dtemp_s3 * dtemp_s3;
	assign sq_cold_full = cold_dev_s3 * cold_dev_s3;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			sq_low_s4   <= sq_low_full[SQ_W-1:0];
			// only meaningful when cold, where it fits
			sq_cold_s4  <= sq_cold_full[SQ_W-1:0];
			off0_s4     <= off0_s3;
			sens0_s4    <= sens0_s3;
			temp_s4     <= temp_s3;
			warm_low_s4 <= warm_low_s3;
			cold_s4     <= cold_s3;
			d1_s4       <= d1_s3;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 5: second-order correction terms
	// ---------------------------------------------------------------------------
	logic [CORR_W-1:0] d5;        // 5 * (temp-2000)^2
	logic [CORR_W-1:0] e7;        // 7 * (temp+1500)^2
	logic [CORR_W:0]   e11;       // 11 * (temp+1500)^2
	logic [CORR_W-1:0] corr_off;
	logic [CORR_W-1:0] corr_sens;

	always_comb begin
		d5  = {1'b0, sq_low_s4, 2'b0} + {3'b0, sq_low_s4};
		e7  = {sq_cold_s4, 3'b0} - {3'b0, sq_cold_s4};
		e11 = {1'b0, sq_cold_s4, 3'b0} + {3'b0, sq_cold_s4, 1'b0} + {4'b0, sq_cold_s4};
		corr_off  = '0;
		corr_sens = '0;
		if (warm_low_s4) begin
			corr_off  = {1'b0, d5[CORR_W-1:1]};
			corr_sens = {2'b0, d5[CORR_W-1:2]};
			if (cold_s4) begin
				corr_off  = corr_off + e7;
				corr_sens = corr_sens + e11[CORR_W:1];
			end
		end
	end

	logic        [CORR_W-1:0] corr_off_s5;
	logic        [CORR_W-1:0] corr_sens_s5;
	logic signed [ACC_W-1:0]  off0_s5;
	logic signed [ACC_W-1:0]  sens0_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic        [RAW_W-1:0]  d1_s5;

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			corr_off_s5  <= corr_off;
			corr_sens_s5 <= corr_sens;
			off0_s5      <= off0_s4;
			sens0_s5     <= sens0_s4;
			temp_s5      <= temp_s4;
			d1_s5        <= d1_s4;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 6: apply corrections
	// ---------------------------------------------------------------------------
	logic signed [ACC_W-1:0]  off_s6;
	logic signed [ACC_W-1:0]  sens_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic        [RAW_W-1:0]  d1_s6;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			off_s6  <= off0_s5 - $signed({2'b0, corr_off_s5});
			sens_s6 <= sens0_s5 - $signed({2'b0, corr_sens_s5});
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 7: d1 * sens as two partial products (low slice unsigned, high signed)
	// ---------------------------------------------------------------------------
	localparam int unsigned HI_W = ACC_W - SPLIT_W;

	logic        [RAW_W+SPLIT_W-1:0]  pp_lo_s7;
	logic signed [RAW_W+HI_W:0]       pp_hi_s7;
	logic signed [ACC_W-1:0]          off_s7;
	logic signed [TEMP_W-1:0]         temp_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			pp_lo_s7 <= d1_s6 * sens_s6[SPLIT_W-1:0];
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[ACC_W-1:SPLIT_W]);
			off_s7   <= off_s6;
			temp_s7  <= temp_s6;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 8: recombine and shift by 21
	// ---------------------------------------------------------------------------
	logic signed [63:0]       prod;
	logic signed [PD_W-1:0]   pd_s8;
	logic signed [ACC_W-1:0]  off_s8;
	logic signed [TEMP_W-1:0] temp_s8;

	// true product fits 64 bits, so the top bit of the high slice is a copy
	assign prod = $signed({pp_hi_s7[RAW_W+HI_W-1:0], {SPLIT_W{1'b0}}})
		+ $signed({{(64-RAW_W-SPLIT_W){1'b0}}, pp_lo_s7});

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			pd_s8   <= prod[63:21];
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// ---------------------------------------------------------------------------
	// stage 9: subtract offset, shift by 15, output register
	// ---------------------------------------------------------------------------
	logic signed [PD_W:0]       press_diff;
	logic signed [PRESS_W-1:0]  press_s9;
	logic signed [TEMP_W-1:0]   temp_s9;

	assign press_diff = $signed({pd_s8[PD_W-1], pd_s8})
		- $signed({{(PD_W+1-ACC_W){off_s8[ACC_W-1]}}, off_s8});

	always_ff @(posedge clk) begin
		if (adv_s9) begin
			press_s9 <= $signed({{(PRESS_W-PD_W+14){press_diff[PD_W]}}, press_diff[PD_W:15]});
			temp_s9  <= temp_s8;
		end
	end

	assign out_valid   = valid_s9;
	assign pressure    = press_s9;
	assign temperature = temp_s9;

	// ---------------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------------
	// an accepted transaction always lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction did not enter stage 1");

	// backpressure reaches the input only with a full pipe and a stalled output
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s5 && valid_s9 && out_stall))
		else $error("input stalled while the pipeline had room");

	// below -15 degC implies below 20 degC
	a_cold_implies_low: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (!cold_s3 || warm_low_s3))
		else $error("cold flag without low-temperature flag");

	// a held stage keeps its correction terms
	a_hold_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !adv_s5) |=> (valid_s5 && $stable(corr_off_s5) && $stable(corr_sens_s5)))
		else $error("stage 5 lost or changed a held transaction");

endmodule

`default_nettype wire

// ----- verif/pressure_temperature_compensation_unit_tb.sv -----
// pressure_temperature_compensation_unit_tb: self-checking bench for the compensation unit
// depends on ptc_pkg and pressure_temperature_compensation_unit
`timescale 1ns / 1ps

module pressure_temperature_compensation_unit_tb;
	import ptc_pkg::*;

	// nine register stages between input accept and output valid
	localparam int PIPE_DEPTH     = 9;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_READINGS = 200;
	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
	localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};
	// register slots past the last calibration word, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [PRESS_W-1:0] pressure;
		logic signed [TEMP_W-1:0]  temperature;
	} comp_reading_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CAL_W-1:0]            cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [RAW_W-1:0]            raw_pressure;
	logic [RAW_W-1:0]            raw_temperature;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [PRESS_W-1:0]   pressure;
	logic signed [TEMP_W-1:0]    temperature;

	// calibration words as the unit should hold them
	calib_t        cal_words;
	// compensated readings still owed by the unit, oldest first
	comp_reading_t pending_readings[$];

	// idle behavior of the two sides, switched per phase
	bit send_idle;
	bit recv_idle;
	int stall_hold;

	int mismatch_count;
	int readings_sent;
	int readings_checked;
	int cal_settings;
	int cool_readings;
	int cold_readings;

	pressure_temperature_compensation_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressure        (pressure),
		.temperature     (temperature)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// second-order compensation in 64-bit signed arithmetic, >>> gives floor division
	function automatic comp_reading_t compensate_reading(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		comp_reading_t r;
		longint d1, d2, dt, off, sens, t, dev, sq, press;
		d1   = longint'(d1_raw);
		d2   = longint'(d2_raw);
		dt   = d2 - longint'(cal_words.reference_temperature) * 256;
		off  = longint'(cal_words.pressure_offset) * 65536
			+ ((longint'(cal_words.offset_temp_coef) * dt) >>> 7);
		sens = longint'(cal_words.pressure_sensitivity) * 32768
			+ ((longint'(cal_words.sensitivity_temp_coef) * dt) >>> 8);
		t    = longint'(TEMP_REF) + ((dt * longint'(cal_words.temperature_coef)) >>> 23);
		// below 20 degC the offset and sensitivity get pulled down
		if (t < longint'(TEMP_REF)) begin
			dev  = t - longint'(TEMP_REF);
			sq   = 5 * dev * dev;
			off  = off - (sq >>> 1);
			sens = sens - (sq >>> 2);
			// extra terms below -15 degC
			if (t < longint'(TEMP_COLD)) begin
				dev  = t - longint'(TEMP_COLD);
				sq   = dev * dev;
				off  = off - 7 * sq;
				sens = sens - ((11 * sq) >>> 1);
			end
		end
		press         = (((d1 * sens) >>> 21) - off) >>> 15;
		// pressure wraps to its low 32 bits
		r.pressure    = press[PRESS_W-1:0];
		r.temperature = t[TEMP_W-1:0];
		return r;
	endfunction

	// result side: compare every accepted transaction with the oldest pending reading,
	// then draw how long to hold off the next one
	always @(posedge clk) begin : result_check
		comp_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result: pressure %0d temperature %0d", pressure, temperature);
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				if (pressure !== want.pressure) begin
					$error("pressure: expected %0d, got %0d", want.pressure, pressure);
					mismatch_count++;
				end
				if (temperature !== want.temperature) begin
					$error("temperature: expected %0d, got %0d", want.temperature, temperature);
					mismatch_count++;
				end
			end
			stall_hold = recv_idle ? int'($urandom_range(0, 19)) : 0;
		end
	end

	// stall is raised after each accepted result and held while stall_hold counts down
	always @(negedge clk) begin
		if (stall_hold != 0) begin
			out_stall = 1'b1;
			stall_hold--;
		end else begin
			out_stall = 1'b0;
		end
	end

	// one input transaction; called and returning at a falling edge
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		int unsigned gap;
		comp_reading_t want;
		gap = send_idle ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        = 1'b1;
		raw_pressure    = d1;
		raw_temperature = d2;
		do @(posedge clk); while (in_stall);
		want = compensate_reading(d1, d2);
		pending_readings.push_back(want);
		readings_sent++;
		if (want.temperature < TEMP_REF)
			cool_readings++;
		if (want.temperature < TEMP_COLD)
			cold_readings++;
		@(negedge clk);
	endtask

	// let the pipeline run empty before touching calibration
	task automatic drain_pipeline();
		in_valid = 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	// one configuration transaction; the local copy follows only when the write lands
	task automatic write_cal_word(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			IDX_PRESSURE_SENSITIVITY:  cal_words.pressure_sensitivity  = data;
			IDX_PRESSURE_OFFSET:       cal_words.pressure_offset       = data;
			IDX_SENSITIVITY_TEMP_COEF: cal_words.sensitivity_temp_coef = data;
			IDX_OFFSET_TEMP_COEF:      cal_words.offset_temp_coef      = data;
			IDX_REFERENCE_TEMPERATURE: cal_words.reference_temperature = data;
			IDX_TEMPERATURE_COEF:      cal_words.temperature_coef      = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_calibration(input calib_t c);
		write_cal_word(IDX_PRESSURE_SENSITIVITY,  c.pressure_sensitivity);
		write_cal_word(IDX_PRESSURE_OFFSET,       c.pressure_offset);
		write_cal_word(IDX_SENSITIVITY_TEMP_COEF, c.sensitivity_temp_coef);
		write_cal_word(IDX_OFFSET_TEMP_COEF,      c.offset_temp_coef);
		write_cal_word(IDX_REFERENCE_TEMPERATURE, c.reference_temperature);
		write_cal_word(IDX_TEMPERATURE_COEF,      c.temperature_coef);
		cal_settings++;
	endtask

	function automatic calib_t nominal_calibration();
		calib_t c;
		c.pressure_sensitivity  = 16'd40127;
		c.pressure_offset       = 16'd36924;
		c.sensitivity_temp_coef = 16'd23317;
		c.offset_temp_coef      = 16'd23282;
		c.reference_temperature = 16'd33464;
		c.temperature_coef      = 16'd28312;
		return c;
	endfunction

	// all calibration words at zero after reset: everything collapses to 20.00 degC, 0 mbar
	task automatic test_reset_values();
		send_reading('0, '0);
		send_reading(RAW_MAX, RAW_MAX);
		send_reading(RAW_MAX, '0);
		drain_pipeline();
	endtask

	// spare register slots must not disturb anything, then a nominal part
	task automatic test_register_map();
		write_cal_word(IDX_SPARE_LO, CAL_MAX);
		write_cal_word(IDX_SPARE_HI, CAL_MAX);
		send_reading(24'd9085466, 24'd8569150);
		drain_pipeline();
		load_calibration(nominal_calibration());
		send_reading(24'd9085466, 24'd8569150);
		send_reading(24'd9085466, 24'd6000000);
		drain_pipeline();
		write_cal_word(IDX_SPARE_HI, 16'h1234);
	endtask

	// temperature coefficient of 2^15 makes temp = 2000 + floor(dt / 256),
	// so dt can be placed exactly on both thresholds
	task automatic test_temperature_thresholds();
		calib_t c;
		logic [RAW_W-1:0] ref_raw;
		c = nominal_calibration();
		c.reference_temperature = CAL_MAX;
		c.temperature_coef      = 16'h8000;
		load_calibration(c);
		ref_raw = RAW_W'(CAL_MAX) << 8;
		send_reading(24'd9085466, ref_raw);              // exactly 20 degC
		send_reading(24'd9085466, ref_raw - 24'd1);      // just below 20 degC
		send_reading(24'd9085466, ref_raw - 24'd896000); // exactly -15 degC
		send_reading(24'd9085466, ref_raw - 24'd896001); // just below -15 degC
		send_reading(RAW_MAX, '0);                        // deepest cold, negative sensitivity
		send_reading('0, RAW_MAX);                        // warm side top
		drain_pipeline();
	endtask

	// all calibration words at their maximum, and the reference dropped to zero
	task automatic test_field_extremes();
		calib_t c;
		c = '{default: CAL_MAX};
		load_calibration(c);
		send_reading('0, '0);
		send_reading('0, RAW_MAX);
		send_reading(RAW_MAX, '0);
		send_reading(RAW_MAX, RAW_MAX);
		drain_pipeline();
		write_cal_word(IDX_REFERENCE_TEMPERATURE, '0);
		send_reading(RAW_MAX, RAW_MAX);
		send_reading(RAW_MAX, 24'd1);
		drain_pipeline();
	endtask

	// several calibration sets, each followed by a stream of random readings;
	// idling on either side is switched per phase so some phases run back to back
	task automatic test_random_streams();
		calib_t c;
		logic [RAW_W-1:0] d1, d2;
		longint centre, span, t_raw;
		int unsigned pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = (phase < 2) ? phase : $urandom_range(0, 3);
			case (pick)
				0: c = nominal_calibration();
				1: c = '{default: '0};
				2: begin
					// each word at an extreme or random
					c = '{default: '0};
					c.pressure_sensitivity  = ($urandom_range(0, 1) != 0) ? CAL_MAX : CAL_W'($urandom);
					c.pressure_offset       = ($urandom_range(0, 1) != 0) ? CAL_MAX : '0;
					c.sensitivity_temp_coef = ($urandom_range(0, 1) != 0) ? CAL_MAX : CAL_W'($urandom);
					c.offset_temp_coef      = ($urandom_range(0, 1) != 0) ? CAL_MAX : '0;
					c.reference_temperature = CAL_W'($urandom);
					c.temperature_coef      = ($urandom_range(0, 1) != 0) ? CAL_MAX : CAL_W'($urandom);
				end
				default: c = calib_t'({$urandom, $urandom, $urandom});
			endcase
			load_calibration(c);
			if ($urandom_range(0, 1) != 0)
				write_cal_word(($urandom_range(0, 1) != 0) ? IDX_SPARE_LO : IDX_SPARE_HI,
					CAL_W'($urandom));
			send_idle = (phase % 4 == 0) || (phase % 4 == 1);
			recv_idle = (phase % 4 == 0) || (phase % 4 == 2);
			stall_hold = recv_idle ? int'($urandom_range(0, 19)) : 0;
			for (int n = 0; n < PHASE_READINGS; n++) begin
				pick = $urandom_range(0, 9);
				d1 = (pick == 0) ? '0 : (pick == 1) ? RAW_MAX : RAW_W'($urandom);
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					d2 = RAW_W'($urandom);
				end else if (pick < 8) begin
					// around the reference point so both thresholds get crossed
					centre = longint'(cal_words.reference_temperature) * 256;
					case ($urandom_range(0, 3))
						0: span = 255;
						1: span = 65535;
						2: span = 1 << 20;
						default: span = 1 << 22;
					endcase
					t_raw = centre - span + longint'($urandom_range(0, int'(2 * span)));
					if (t_raw < 0)
						t_raw = 0;
					if (t_raw > longint'(RAW_MAX))
						t_raw = longint'(RAW_MAX);
					d2 = t_raw[RAW_W-1:0];
				end else begin
					d2 = (pick == 8) ? '0 : RAW_MAX;
				end
				send_reading(d1, d2);
			end
			drain_pipeline();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		raw_pressure    = '0;
		raw_temperature = '0;
		out_stall       = 1'b0;
		stall_hold      = 0;
		cal_words       = '{default: '0};
		send_idle       = 1'b1;
		recv_idle       = 1'b1;
		mismatch_count  = 0;
		readings_sent   = 0;
		readings_checked = 0;
		cal_settings    = 0;
		cool_readings   = 0;
		cold_readings   = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_register_map();
		test_temperature_thresholds();
		test_field_extremes();
		test_random_streams();

		// tail: catch any result that shows up after the last expected one
		repeat (2 * PIPE_DEPTH) @(negedge clk);
		$display("compensated %0d readings (%0d checked) over %0d calibration sets",
			readings_sent, readings_checked, cal_settings);
		$display("%0d readings below 20 degC, %0d of them below -15 degC",
			cool_readings, cold_readings);
		if (mismatch_count == 0) begin
			$display("pressure_temperature_compensation_unit_tb: clean");
		end else begin
			$display("pressure_temperature_compensation_unit_tb: errors");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d readings outstanding", pending_readings.size());
		$display("pressure_temperature_compensation_unit_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ptc_pkg.sv
src/ptc_regs.sv
src/pressure_temperature_compensation_unit.sv
verif/pressure_temperature_compensation_unit_tb.sv
